// ----- rtl/core/spbf_pkg.sv -----
// Package for the slot pool allocator: pool limits, status codes and the
// layout of one slot memory entry. No dependencies.
package spbf_pkg;

  // Pool limits
  localparam int MAX_SLOTS      = 512;
  localparam int MAX_SLOT_BYTES = 8192;

  // Field widths
  localparam int SLOT_W  = $clog2(MAX_SLOTS);   // slot index
  localparam int COUNT_W = SLOT_W + 1;          // counts up to MAX_SLOTS
  localparam int BYTES_W = 14;                  // per-request byte sizes
  localparam int USED_W  = 23;                  // running used-byte total

  localparam logic [COUNT_W-1:0] MAX_SLOTS_C      = COUNT_W'(MAX_SLOTS);
  localparam logic [BYTES_W-1:0] MAX_SLOT_BYTES_C = BYTES_W'(MAX_SLOT_BYTES);
  localparam logic [USED_W-1:0]  USED_MAX         = {USED_W{1'b1}};

  // Result status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_EXHAUSTED = 2'd1;
  localparam logic [1:0] STATUS_TOO_LARGE = 2'd2;
  localparam logic [1:0] STATUS_NOT_LIVE  = 2'd3;

  // Request kinds
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Configuration register indexes
  localparam logic CFG_SLOT_COUNT    = 1'b0;
  localparam logic CFG_SLOT_CAPACITY = 1'b1;

  // One entry of the per-slot memory
  typedef struct packed {
    logic               live;
    logic [BYTES_W-1:0] bytes;
  } slot_entry_t;

  localparam int SLOT_ENTRY_W = $bits(slot_entry_t);

endpackage

// ----- rtl/core/slot_pool_bump_and_free_stack.sv -----
// Slot pool allocator: bump index, freed-slot stack and per-slot live/size memory.
// Per request: a read step on accept (capture, memory reads), then an update step
// that waits on out_stall; in_stall holds off the next request until it is done.
// Reset: synchronous; counters and used total go to zero, config to count 512 / capacity 8.
// A live mark is only trusted below the bump index, so no clearing pass is needed.
// Depends on spbf_pkg and spbf_ram.
module slot_pool_bump_and_free_stack
  import spbf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [BYTES_W-1:0] cfg_data,
  // request channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               req_type,
  input  logic [BYTES_W-1:0] request_size,
  input  logic [BYTES_W-1:0] data_size,
  input  logic [SLOT_W-1:0]  slot_index,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [SLOT_W-1:0]  granted_slot,
  output logic [USED_W-1:0]  bytes_in_use
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic               state;
  logic [COUNT_W-1:0] slot_count;
  logic [BYTES_W-1:0] slot_capacity;
  logic [COUNT_W-1:0] fresh_next;
  logic [COUNT_W-1:0] stack_depth;
  logic [USED_W-1:0]  used_total;

  // captured request
  logic               req_type_q;
  logic [BYTES_W-1:0] request_size_q;
  logic [BYTES_W-1:0] data_size_q;
  logic [SLOT_W-1:0]  slot_index_q;

  logic in_fire;
  logic done;

  // memory ports
  logic                    slot_we;
  logic [SLOT_W-1:0]       slot_waddr;
  slot_entry_t             slot_wentry;
  logic [SLOT_ENTRY_W-1:0] slot_rdata;
  slot_entry_t             slot_rentry;
  logic                    stack_we;
  logic [SLOT_W-1:0]       stack_rdata;
  logic [SLOT_W-1:0]       stack_raddr;

  // decision
  logic [COUNT_W-1:0] cnt_eff;
  logic [BYTES_W-1:0] cap_eff;
  logic [USED_W:0]    used_sum;
  logic [USED_W-1:0]  used_add;
  logic [USED_W-1:0]  used_sub;
  logic               slot_live_rd;
  logic [1:0]         status_next;
  logic [SLOT_W-1:0]  granted_next;
  logic [USED_W-1:0]  used_total_next;
  logic [COUNT_W-1:0] fresh_next_next;
  logic [COUNT_W-1:0] stack_depth_next;

  assign in_stall = (state == ST_EXEC);
  assign in_fire  = in_valid && !in_stall;
  assign done     = (state == ST_EXEC) && (!out_valid || !out_stall);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count    <= MAX_SLOTS_C;
      slot_capacity <= BYTES_W'(8);
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_SLOT_COUNT:    slot_count    <= cfg_data[COUNT_W-1:0];
        CFG_SLOT_CAPACITY: slot_capacity <= cfg_data;
        default: ;
      endcase
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_type_q     <= req_type;
      request_size_q <= request_size;
      data_size_q    <= data_size;
      slot_index_q   <= slot_index;
    end
  end

  // control FSM
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else if (in_fire) begin
      state <= ST_EXEC;
    end else if (done) begin
      state <= ST_IDLE;
    end
  end

  // top of stack read address, wraps harmlessly when the stack is empty
  assign stack_raddr = stack_depth[SLOT_W-1:0] - SLOT_W'(1);

  spbf_ram #(
    .DEPTH (MAX_SLOTS),
    .WIDTH (SLOT_ENTRY_W)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wentry),
    .re    (in_fire),
    .raddr (slot_index),
    .rdata (slot_rdata)
  );

  spbf_ram #(
    .DEPTH (MAX_SLOTS),
    .WIDTH (SLOT_W)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stack_we),
    .waddr (stack_depth[SLOT_W-1:0]),
    .wdata (slot_index_q),
    .re    (in_fire),
    .raddr (stack_raddr),
    .rdata (stack_rdata)
  );

  assign slot_rentry = slot_entry_t'(slot_rdata);

  // effective limits and saturating arithmetic
  assign cnt_eff  = (slot_count > MAX_SLOTS_C) ? MAX_SLOTS_C : slot_count;
  assign cap_eff  = (slot_capacity > MAX_SLOT_BYTES_C) ? MAX_SLOT_BYTES_C : slot_capacity;
  assign used_sum = {1'b0, used_total} + (USED_W + 1)'(data_size_q);
  assign used_add = used_sum[USED_W] ? USED_MAX : used_sum[USED_W-1:0];
  assign used_sub = (USED_W'(slot_rentry.bytes) > used_total) ? '0
                  : used_total - USED_W'(slot_rentry.bytes);

  // entries at or above the bump index were never handed out
  assign slot_live_rd = ({1'b0, slot_index_q} < fresh_next) && slot_rentry.live;

  // request decision, applied on done
  always_comb begin
    status_next      = STATUS_OK;
    granted_next     = '0;
    used_total_next  = used_total;
    fresh_next_next  = fresh_next;
    stack_depth_next = stack_depth;
    slot_we          = 1'b0;
    slot_waddr       = slot_index_q;
    slot_wentry      = slot_rentry;
    stack_we         = 1'b0;
    if (req_type_q == REQ_ALLOC) begin
      if (request_size_q > cap_eff) begin
        status_next = STATUS_TOO_LARGE;
      end else if (fresh_next < cnt_eff) begin
        granted_next    = fresh_next[SLOT_W-1:0];
        fresh_next_next = fresh_next + COUNT_W'(1);
      end else if (stack_depth != '0) begin
        granted_next     = stack_rdata;
        stack_depth_next = stack_depth - COUNT_W'(1);
      end else begin
        status_next = STATUS_EXHAUSTED;
      end
      if (status_next == STATUS_OK) begin
        slot_we           = 1'b1;
        slot_waddr        = granted_next;
        slot_wentry.live  = 1'b1;
        slot_wentry.bytes = data_size_q;
        used_total_next   = used_add;
      end
    end else begin
      if (!slot_live_rd) begin
        status_next = STATUS_NOT_LIVE;
      end else begin
        slot_we          = 1'b1;
        slot_wentry.live = 1'b0;
        used_total_next  = used_sub;
        // a push onto a full stack is dropped
        if (stack_depth < MAX_SLOTS_C) begin
          stack_we         = 1'b1;
          stack_depth_next = stack_depth + COUNT_W'(1);
        end
      end
    end
    slot_we  = slot_we && done;
    stack_we = stack_we && done;
  end

  // pool state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fresh_next  <= '0;
      stack_depth <= '0;
      used_total  <= '0;
    end else if (done) begin
      fresh_next  <= fresh_next_next;
      stack_depth <= stack_depth_next;
      used_total  <= used_total_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      status       <= status_next;
      granted_slot <= granted_next;
      bytes_in_use <= used_total_next;
    end
  end

endmodule

// ----- rtl/core/spbf_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module spbf_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 15
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
